// File: sv/str_pkg.sv
`timescale 1ns / 1ps

package str_pkg;

  localparam int COLUMNS     = 48;
  localparam int ROWS        = 8;
  localparam int MAX_CHARS   = 64;

  localparam int GLYPH_SLOTS = 65;
  localparam int GLYPH_WIDTH = 5;
  localparam int GLYPH_PITCH = 6;
  localparam int GLYPH_ROWS  = 7;
  localparam int FONT_DEPTH  = GLYPH_SLOTS * GLYPH_WIDTH;
  localparam int FONT_AW     = $clog2(FONT_DEPTH);
  localparam int MSG_AW      = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  localparam logic [6:0] SLOT_SPACE = 7'd36;
  localparam logic [6:0] SLOT_BANG  = 7'd37;
  localparam logic [6:0] SLOT_BLANK = 7'd38;

  // Reciprocal of the glyph pitch, scaled by 2**10; exact for offsets below 512.
  localparam int RECIP_SHIFT = 10;
  localparam logic [7:0] RECIP_PITCH = 8'd171;

  localparam logic [1:0] OP_FONT   = 2'd0;
  localparam logic [1:0] OP_CHAR   = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;
  localparam logic [1:0] OP_STEP   = 2'd3;

  localparam logic [23:0] WHITE = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] glyph_index;
    logic [2:0] glyph_column;
    logic [6:0] column_bits;
    logic [5:0] char_position;
    logic [7:0] char_code;
    logic [5:0] pixel_x;
    logic [2:0] pixel_y;
  } item_t;

  typedef struct packed {
    logic signed [9:0] offset;
    logic [23:0]       color;
    logic [6:0]        shown_len;
  } frame_t;

  function automatic logic [23:0] palette(input logic [2:0] slot);
    logic [23:0] c;
    case (slot)
      3'd0:    c = 24'hFF0000;
      3'd1:    c = 24'h00FF00;
      3'd2:    c = 24'h0000FF;
      3'd3:    c = 24'hFFFF00;
      3'd4:    c = 24'h00FFFF;
      3'd5:    c = 24'hFF00FF;
      default: c = WHITE;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] slot_of(input logic [7:0] c);
    logic [6:0] s;
    if (c >= 8'h41 && c <= 8'h5A)      s = 7'(c - 8'h41);
    else if (c >= 8'h30 && c <= 8'h39) s = 7'(c - 8'h30) + 7'd26;
    else if (c == 8'h20)               s = SLOT_SPACE;
    else if (c == 8'h21)               s = SLOT_BANG;
    else if (c >= 8'h61 && c <= 8'h7A) s = 7'(c - 8'h61) + 7'd39;
    else                               s = SLOT_BLANK;
    return s;
  endfunction

endpackage

// File: sv/scrolling_text_pixel_renderer.sv
`timescale 1ns / 1ps

// Scrolling text renderer for a 48 x 8 serpentine LED matrix. Each input word
// carries an op in tuser: load a font column, load a message character, render
// one pixel, or advance the scroll by one column. Only render words produce an
// output word, which passes through the message store read, the font store read
// and the output register, all pipelined, so one word is accepted every cycle
// when there is no backpressure. Font and message stores come up undefined and
// need no clearing pass; a word is accepted whenever the output register is empty
// or being drained.
module scrolling_text_pixel_renderer
  import str_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,      // message_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // glyph_index[6:0], glyph_column[9:7], column_bits[16:10], char_position[22:17],
  // char_code[30:23], pixel_x[36:31], pixel_y[39:37]
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // strip_index[8:0], pixel_color[32:9], lit[33], zero fill[39:34]
  output logic [39:0] m_axis_tdata
);

  item_t       item;
  frame_t      frame;
  logic        adv;
  logic        accept;
  logic [8:0]  out_index;
  logic [23:0] out_color;
  logic        out_lit;

  assign item.op            = s_axis_tuser;
  assign item.glyph_index   = s_axis_tdata[6:0];
  assign item.glyph_column  = s_axis_tdata[9:7];
  assign item.column_bits   = s_axis_tdata[16:10];
  assign item.char_position = s_axis_tdata[22:17];
  assign item.char_code     = s_axis_tdata[30:23];
  assign item.pixel_x       = s_axis_tdata[36:31];
  assign item.pixel_y       = s_axis_tdata[39:37];

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  str_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .step      (accept && item.op == OP_STEP),
    .frame     (frame)
  );

  str_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .adv       (adv),
    .item      (item),
    .frame     (frame),
    .out_valid (m_axis_tvalid),
    .out_index (out_index),
    .out_color (out_color),
    .out_lit   (out_lit)
  );

  assign m_axis_tdata = {6'd0, out_lit, out_color, out_index};

endmodule

// File: sv/str_ram.sv
`timescale 1ns / 1ps

module str_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/str_frame.sv
`timescale 1ns / 1ps

module str_frame
  import str_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [6:0] cfg_wdata,
  input  logic       step,
  output frame_t     frame
);

  logic signed [9:0]  offset;
  logic [2:0]         color_slot;
  logic [23:0]        color;
  logic [6:0]         message_length;
  logic [6:0]         shown_len;
  logic signed [9:0]  offset_dec;
  logic signed [10:0] limit;
  logic [2:0]         slot_next;

  assign shown_len  = (32'(message_length) > MAX_CHARS) ? 7'(MAX_CHARS) : message_length;
  assign offset_dec = offset - 10'sd1;
  assign limit      = -$signed({1'b0, 10'(shown_len) * 10'd6});
  assign slot_next  = (color_slot == 3'd6) ? 3'd0 : color_slot + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset         <= 10'(COLUMNS);
      color_slot     <= 3'd0;
      color          <= WHITE;
      message_length <= 7'd0;
    end else begin
      if (cfg_wen) begin
        message_length <= cfg_wdata;
      end
      if (step) begin
        // Once the whole message has left the screen, restart at the right edge.
        if ($signed({offset_dec[9], offset_dec}) < limit) begin
          offset     <= 10'(COLUMNS);
          color_slot <= slot_next;
          color      <= palette(slot_next);
        end else begin
          offset <= offset_dec;
        end
      end
    end
  end

  assign frame.offset    = offset;
  assign frame.color     = color;
  assign frame.shown_len = shown_len;

endmodule

// File: sv/str_pipe.sv
`timescale 1ns / 1ps

module str_pipe
  import str_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        adv,
  input  item_t       item,
  input  frame_t      frame,
  output logic        out_valid,
  output logic [8:0]  out_index,
  output logic [23:0] out_color,
  output logic        out_lit
);

  // Address stage: position within the scrolled text.
  logic signed [10:0] rel;
  logic [8:0]         r;
  logic [16:0]        prod;
  logic [6:0]         ch;
  logic [8:0]         col_full;
  logic [2:0]         col;
  logic               on_screen;
  logic               may_light;
  logic [11:0]        row_base;
  logic [11:0]        idx_full;
  logic [8:0]         idx0;

  assign rel      = $signed({5'b0, item.pixel_x}) - $signed({frame.offset[9], frame.offset});
  assign r        = rel[8:0];
  assign prod     = 17'(r) * 17'(RECIP_PITCH);
  assign ch       = prod[RECIP_SHIFT +: 7];
  assign col_full = r - 9'(ch) * 9'(GLYPH_PITCH);
  assign col      = col_full[2:0];

  assign on_screen = (32'(item.pixel_x) < COLUMNS) && (32'(item.pixel_y) < ROWS);
  assign may_light = on_screen && (32'(item.pixel_y) < GLYPH_ROWS) && !rel[10]
                     && (ch < frame.shown_len) && (32'(col) < GLYPH_WIDTH);

  assign row_base = 12'(item.pixel_y) * 12'(COLUMNS);
  assign idx_full = item.pixel_y[0] ? row_base + 12'(COLUMNS - 1) - 12'(item.pixel_x)
                                    : row_base + 12'(item.pixel_x);
  assign idx0     = on_screen ? idx_full[8:0] : 9'd0;

  logic       msg_we;
  logic       font_we;
  logic [7:0] msg_rdata;
  logic [6:0] font_rdata;
  logic [FONT_AW-1:0] font_waddr;
  logic [FONT_AW-1:0] font_raddr;

  assign msg_we  = accept && item.op == OP_CHAR && 32'(item.char_position) < MAX_CHARS;
  assign font_we = accept && item.op == OP_FONT
                   && 32'(item.glyph_index) < GLYPH_SLOTS
                   && 32'(item.glyph_column) < GLYPH_WIDTH;
  assign font_waddr = FONT_AW'(item.glyph_index) * FONT_AW'(GLYPH_WIDTH)
                      + FONT_AW'(item.glyph_column);

  str_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_msg (
    .clk   (clk),
    .we    (msg_we),
    .waddr (MSG_AW'(item.char_position)),
    .wdata (item.char_code),
    .re    (adv),
    .raddr (MSG_AW'(ch)),
    .rdata (msg_rdata)
  );

  // Message stage registers.
  logic        v1;
  logic [8:0]  idx1;
  logic [2:0]  y1;
  logic [2:0]  col1;
  logic        may1;
  logic [23:0] color1;

  assign font_raddr = FONT_AW'(slot_of(msg_rdata)) * FONT_AW'(GLYPH_WIDTH) + FONT_AW'(col1);

  str_ram #(.WIDTH(7), .DEPTH(FONT_DEPTH)) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (item.column_bits),
    .re    (adv),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  // Font stage registers.
  logic        v2;
  logic [8:0]  idx2;
  logic [2:0]  y2;
  logic        may2;
  logic [23:0] color2;
  logic        lit2;
  logic [7:0]  font_bits;

  // The bottom row has no font bit and always reads dark.
  assign font_bits = {1'b0, font_rdata};
  assign lit2      = may2 && (y2 < 3'(GLYPH_ROWS)) && font_bits[y2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= accept && item.op == OP_RENDER;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1      <= idx0;
      y1        <= item.pixel_y;
      col1      <= col;
      may1      <= may_light;
      color1    <= frame.color;
      idx2      <= idx1;
      y2        <= y1;
      may2      <= may1;
      color2    <= color1;
      out_index <= idx2;
      out_lit   <= lit2;
      out_color <= lit2 ? color2 : 24'd0;
    end
  end

endmodule

// File: sv/str_checker.sv
`timescale 1ns / 1ps

module str_checker
  import str_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // An unlit pixel is always black.
  a_dark: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[33] |-> m_axis_tdata[32:9] == 24'd0)
    else $error("unlit pixel carries a color");

  // Strip positions stay on the matrix.
  a_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 32'(m_axis_tdata[8:0]) < COLUMNS * ROWS)
    else $error("strip index off the matrix");

  // The input side never stalls while the output register is empty.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind scrolling_text_pixel_renderer str_checker u_str_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
